// ===== rtl/erma_pkg.sv =====
// erma_pkg: constants, types and helper functions for the echo range moving average
// used by erma_ring_avg and echo_range_moving_average; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package erma_pkg;

	// field widths
	localparam int TIME_W   = 17;
	localparam int RAW_W    = 12;
	localparam int DIST_W   = 10;
	localparam int DIGIT_W  = 4;

	// ring geometry
	localparam int RING_DEPTH = 4;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int SUM_W      = DIST_W + $clog2(RING_DEPTH);

	// register reset value
	localparam logic [DIST_W-1:0] MAX_RANGE_RESET = DIST_W'(400);

	// reciprocal of 58 scaled by 2^20, exact for every 17 bit pulse width
	localparam int                 CM_RECIP_SHIFT = 20;
	localparam logic [14:0]        CM_RECIP       = 15'd18079;
	localparam int                 CM_PROD_W      = TIME_W + 15;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 40;
	localparam int OUT_PAD_W  = OUT_DATA_W - (RAW_W + 1 + DIST_W + 1 + 3 * DIGIT_W);

	// one result item, lowest field last
	typedef struct packed {
		logic [OUT_PAD_W-1:0] pad;
		logic [DIGIT_W-1:0]   digit_ones;
		logic [DIGIT_W-1:0]   digit_tens;
		logic [DIGIT_W-1:0]   digit_hundreds;
		logic                 average_changed;
		logic [DIST_W-1:0]    average_cm;
		logic                 sample_accepted;
		logic [RAW_W-1:0]     raw_distance_cm;
	} erma_result_t;

	// one measured sample handed to the ring stage
	typedef struct packed {
		logic             valid;
		logic [RAW_W-1:0] raw;
	} erma_sample_t;

	// pulse width in microseconds to distance in cm, truncated
	function automatic logic [RAW_W-1:0] cm_from_width(input logic [TIME_W-1:0] width);
		logic [CM_PROD_W-1:0] prod;
		prod = CM_PROD_W'(width) * CM_PROD_W'(CM_RECIP);
		return RAW_W'(prod >> CM_RECIP_SHIFT);
	endfunction

	// three decimal digits of a 10 bit value, hundreds wrap past 999
	function automatic logic [3*DIGIT_W-1:0] to_digits(input logic [DIST_W-1:0] val);
		logic [20:0] p10;
		logic [16:0] p100;
		logic [6:0]  q10;
		logic [3:0]  q100;
		logic [3:0]  hund;
		logic [3:0]  tens;
		logic [3:0]  ones;
		// x*205 >> 11 is x/10 and x*41 >> 12 is x/100 over the 10 bit range
		p10  = 21'(val) * 21'd205;
		p100 = 17'(val) * 17'd41;
		q10  = 7'(p10 >> 11);
		q100 = 4'(p100 >> 12);
		hund = (q100 >= 4'd10) ? 4'(q100 - 4'd10) : q100;
		tens = 4'(q10 - 7'(q100 * 4'd10));
		ones = 4'(val - DIST_W'(q10 * 4'd10));
		return {hund, tens, ones};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/erma_ring_avg.sv =====
// erma_ring_avg: sample ring, write index, stable distance and the result logic
// depends on erma_pkg
`timescale 1ns / 1ps
`default_nettype none

module erma_ring_avg (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire erma_pkg::erma_sample_t  sample,
	input  wire logic [erma_pkg::DIST_W-1:0] max_range_cm,
	output erma_pkg::erma_result_t       result
);
	import erma_pkg::*;

	logic [DIST_W-1:0] ring_q [RING_DEPTH];
	logic [IDX_W-1:0]  wr_idx_q;
	logic [DIST_W-1:0] stable_q;

	logic              store;
	logic [DIST_W-1:0] ring_next [RING_DEPTH];
	logic [SUM_W-1:0]  sum;
	logic [DIST_W-1:0] avg;
	logic [IDX_W-1:0]  wr_idx_next;

	// store decision and next ring contents
	always_comb begin
		store = sample.valid && (sample.raw < RAW_W'(max_range_cm));
		for (int i = 0; i < RING_DEPTH; i++) begin
			ring_next[i] = ring_q[i];
			if (store && (wr_idx_q == IDX_W'(i))) begin
				ring_next[i] = DIST_W'(sample.raw);
			end
		end
		if (wr_idx_q == IDX_W'(RING_DEPTH - 1)) begin
			wr_idx_next = '0;
		end else begin
			wr_idx_next = wr_idx_q + 1'b1;
		end
	end

	// ring sum and truncated average over the updated ring
	always_comb begin
		sum = '0;
		for (int i = 0; i < RING_DEPTH; i++) begin
			sum = sum + SUM_W'(ring_next[i]);
		end
		avg = DIST_W'(sum / RING_DEPTH);
	end

	// result fields; stable distance after the update always equals the average
	always_comb begin
		result                 = '0;
		result.raw_distance_cm = sample.raw;
		result.sample_accepted = store;
		result.average_cm      = avg;
		result.average_changed = (avg != stable_q);
		{result.digit_hundreds, result.digit_tens, result.digit_ones} = to_digits(avg);
	end

	// state update once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			wr_idx_q <= '0;
			stable_q <= '0;
		end else if (sample.valid) begin
			for (int i = 0; i < RING_DEPTH; i++) begin
				ring_q[i] <= ring_next[i];
			end
			if (store) begin
				wr_idx_q <= wr_idx_next;
			end
			stable_q <= avg;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/echo_range_moving_average.sv =====
// echo_range_moving_average: top level, stream ports, pipeline and range register
// depends on erma_pkg and erma_ring_avg
//
// Usage:
//   s_axis carries one echo measurement per transaction, m_axis one result per
//   measurement, in order. cfg_wr_en with cfg_wr_data writes max_range_cm at the
//   clock edge; write it only while no measurement is in flight.
//   Pipeline: input register, distance register (pulse width divided by 58 via
//   a reciprocal multiply), then the ring update and result register.
//   An accepted input reaches tvalid on m_axis through the input, distance and
//   output registers. Throughput is one transaction per cycle while m_axis does
//   not stall; the ring, its write index and the stable distance are updated in
//   the last stage, so each measurement sees the ring left by the one before it.
//   When the receiver holds m_axis_tready low, the result stays in the output
//   register and the stages behind it keep filling; s_axis_tready falls once
//   all three stages hold an item.
//   Reset clears the ring and the stable distance to zero, the write index to
//   zero, the range register to 400, and empties every stage.
`timescale 1ns / 1ps
`default_nettype none

module echo_range_moving_average (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// config register
	input  wire                                  cfg_wr_en,
	input  wire logic [erma_pkg::DIST_W-1:0]     cfg_wr_data,  // max_range_cm
	// measurement input
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [erma_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // rise_time_us, fall_time_us, pad
	// result output
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [erma_pkg::OUT_DATA_W-1:0]      m_axis_tdata   // raw_distance_cm, sample_accepted,
	                                                            // average_cm, average_changed,
	                                                            // digit_hundreds, digit_tens,
	                                                            // digit_ones, pad
);
	import erma_pkg::*;

	logic [DIST_W-1:0] max_range_q;

	logic              valid_s1;
	logic [TIME_W-1:0] rise_s1;
	logic [TIME_W-1:0] fall_s1;

	logic              valid_s2;
	logic              ok_s2;
	logic [RAW_W-1:0]  raw_s2;

	logic              out_valid_q;
	erma_result_t      out_q;

	logic              out_free;
	logic              adv2;
	logic              s2_free;
	logic              s1_free;
	logic              in_take;
	logic              fall_ok;
	logic [RAW_W-1:0]  raw_dist;
	erma_sample_t      sample;
	erma_result_t      result;

	// stage flow control
	always_comb begin
		out_free      = !out_valid_q || m_axis_tready;
		adv2          = valid_s2 && out_free;
		s2_free       = !valid_s2 || out_free;
		s1_free       = !valid_s1 || s2_free;
		s_axis_tready = s1_free;
		in_take       = s_axis_tvalid && s1_free;
	end

	// range register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_range_q <= MAX_RANGE_RESET;
		end else if (cfg_wr_en) begin
			max_range_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			rise_s1 <= s_axis_tdata[TIME_W-1:0];
			fall_s1 <= s_axis_tdata[2*TIME_W-1:TIME_W];
		end
	end

	// pulse width to distance, rejected when fall precedes rise
	always_comb begin
		fall_ok  = (fall_s1 >= rise_s1);
		raw_dist = fall_ok ? cm_from_width(fall_s1 - rise_s1) : '0;
	end

	// distance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			ok_s2  <= fall_ok;
			raw_s2 <= raw_dist;
		end
	end

	// ring stage sees a sample only when it moves to the output register
	always_comb begin
		sample.valid = adv2 && ok_s2;
		sample.raw   = raw_s2;
	end

	erma_ring_avg u_ring (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.max_range_cm (max_range_q),
		.result       (result)
	);

	// output register; a rejected sample arrives with zero distance and is not stored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
